@@ rtl/variable_record_ring_buffer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the variable record ring buffer
// Shorthand for clocked implication checks with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH
`define VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRRB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vrrb check failed");

// The consequent must hold in the cycle after the antecedent.
`define VRRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vrrb check failed");

`endif

@@ rtl/vrrb_pkg.sv @@
// ----------------------------------------------------------------------------
// Variable record ring buffer package
// Sizes, codes and types shared by the ring buffer modules.
// ----------------------------------------------------------------------------
package vrrb_pkg;

	localparam int REGION_BYTES = 4096;
	localparam int PTR_W        = $clog2(REGION_BYTES);
	localparam int HEAD_BYTES   = 4;
	localparam int LEN_W        = 13;
	localparam int WORD_W       = LEN_W + 1;
	localparam int NEED_W       = LEN_W + 1;
	localparam int SUM_W        = LEN_W + 2;
	localparam int CNT_W        = 10;
	localparam int HELD_MAX     = 1023;
	localparam int DROP_TRIES   = REGION_BYTES / 4 + 2;
	localparam int TRY_W        = $clog2(DROP_TRIES + 1);
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 48;

	localparam logic CFG_USABLE_SIZE = 1'b0;
	localparam logic CFG_DROP_OLDEST = 1'b1;

	localparam logic FN_PUT  = 1'b0;
	localparam logic FN_TAKE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BAD_LEN  = 2'd3
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0] chunk_count;
		logic [CNT_W-1:0] dropped;
		logic [LEN_W-1:0] length;
		logic [PTR_W-1:0] payload_offset;
		status_t          status;
	} result_t;

	localparam int RES_W = $bits(result_t);

endpackage

@@ rtl/variable_record_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// Variable record ring buffer
// Pointer manager for a byte ring of length-prefixed records, with wrap
// markers and optional discard of the oldest records.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s        in         tuser: func; tdata: size
// m        out        tdata: status, payload_offset, length, dropped, chunk_count
// cfg      in         write of usable_size (index 0) or drop_oldest (index 1)
//
// A put passes through RSUM and RDEC to its result, and COMMIT when it restarts
// at offset zero; a take ends in TCHK on an empty ring, else reads the length
// in TLEN, or in TW0 after a wrap marker. The sequencer walks each discarded
// record via DCHK, DLEN and (at a marker) DW0 on the length RAM's single read port.
// Reset leaves the ring empty; the length memory is not cleared.
// A result waiting on m blocks only the next result, not the next acceptance.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [vrrb_pkg::IN_DATA_W-1:0] s_tdata,   // size
	input  logic [0:0]                     s_tuser,   // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status, payload_offset, length, dropped, chunk_count
	output logic [vrrb_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [vrrb_pkg::LEN_W-1:0]     cfg_data
);

	import vrrb_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_RSUM   = 11'b000_0000_0010,
		S_RDEC   = 11'b000_0000_0100,
		S_COMMIT = 11'b000_0000_1000,
		S_DCHK   = 11'b000_0001_0000,
		S_DLEN   = 11'b000_0010_0000,
		S_DW0    = 11'b000_0100_0000,
		S_TCHK   = 11'b000_1000_0000,
		S_TLEN   = 11'b001_0000_0000,
		S_TW0    = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [PTR_W-1:0]  wp_q, wp_d;
	logic [PTR_W-1:0]  rp_q, rp_d;
	logic [CNT_W-1:0]  held_q, held_d;
	logic [LEN_W-1:0]  usable_q;
	logic              drop_q;
	logic              m_tvalid_q;
	result_t           out_q;

	logic [LEN_W-1:0]  size_q;
	logic [NEED_W-1:0] need_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  dropped_q, dropped_d;
	logic [TRY_W-1:0]  tries_q, tries_d;
	result_t           res_q, res_d;

	logic [LEN_W-1:0]  alu_a;
	logic [NEED_W-1:0] alu_b;
	logic [3:0]        alu_k;
	logic [SUM_W-1:0]  alu_sum;

	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [PTR_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic [LEN_W-1:0]  limit;
	logic              accept;
	logic              out_free;
	logic              rd_mark;
	logic [LEN_W-1:0]  rd_len;
	logic              c_block;
	logic              c_wrap;
	logic              can_drop;
	logic              len_bad_now;
	logic              len_bad_w0;
	logic [CNT_W-1:0]  held_inc;
	logic [CNT_W-1:0]  held_dec;
	logic [CNT_W-1:0]  dropped_inc;
	logic [PTR_W-1:0]  wp_off;
	logic [PTR_W-1:0]  rp_off;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_q};

	assign limit = (usable_q > LEN_W'(REGION_BYTES)) ? LEN_W'(REGION_BYTES) : usable_q;

	assign rd_mark = ram_rdata[LEN_W];
	assign rd_len  = ram_rdata[LEN_W-1:0];

	assign c_block  = (wp_q < rp_q) && (SUM_W'(rp_q) <= sum_q);
	assign c_wrap   = sum_q > SUM_W'(limit);
	assign can_drop = drop_q && (tries_q < TRY_W'(DROP_TRIES));

	assign len_bad_now = (rd_len == '0) || (rd_len > limit);
	assign len_bad_w0  = rd_mark || len_bad_now;

	assign held_inc    = (held_q < CNT_W'(HELD_MAX)) ? held_q + 1'b1 : held_q;
	assign held_dec    = (held_q != '0) ? held_q - 1'b1 : held_q;
	assign dropped_inc = (dropped_q < CNT_W'(HELD_MAX)) ? dropped_q + 1'b1 : dropped_q;
	assign wp_off      = wp_q + PTR_W'(HEAD_BYTES);
	assign rp_off      = rp_q + PTR_W'(HEAD_BYTES);

	// Shared adder: a + b + small constant, operands chosen by the sequencer.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_k = '0;
		case (state_q)
			S_IDLE: begin
				alu_a = s_tdata[LEN_W-1:0];
				alu_k = 4'(2 * HEAD_BYTES);
			end
			S_RSUM: begin
				alu_a = LEN_W'(wp_q);
				alu_b = need_q;
			end
			S_RDEC: begin
				alu_a = LEN_W'(wp_q);
				alu_b = NEED_W'(size_q);
				alu_k = 4'(HEAD_BYTES);
			end
			S_COMMIT: begin
				alu_b = NEED_W'(size_q);
				alu_k = 4'(HEAD_BYTES);
			end
			S_DLEN, S_TLEN: begin
				alu_a = LEN_W'(rp_q);
				alu_b = NEED_W'(rd_len);
				alu_k = 4'(HEAD_BYTES);
			end
			S_DW0, S_TW0: begin
				alu_b = NEED_W'(rd_len);
				alu_k = 4'(HEAD_BYTES);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_sum = SUM_W'(alu_a) + SUM_W'(alu_b) + SUM_W'(alu_k);

	assign ram_raddr = ((state_q == S_DLEN) || (state_q == S_TLEN)) ? '0 : rp_q;

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		held_d    = held_q;
		dropped_d = dropped_q;
		tries_d   = tries_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = {1'b0, size_q};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					dropped_d = '0;
					tries_d   = '0;
					state_d   = (s_tuser[0] == FN_TAKE) ? S_TCHK : S_RSUM;
				end
			end
			S_RSUM: begin
				state_d = S_RDEC;
			end
			S_RDEC: begin
				if (c_block || (c_wrap && (rp_q == '0)) ||
				    (c_wrap && (SUM_W'(need_q) >= SUM_W'(rp_q)))) begin
					if (c_wrap && !c_block && (rp_q != '0)) begin
						ram_we    = 1'b1;
						ram_wdata = '1;
					end
					if (can_drop) begin
						state_d = S_DCHK;
					end else begin
						res_d   = '{chunk_count: held_q, dropped: dropped_q, length: '0,
						            payload_offset: '0, status: ST_NO_SPACE};
						state_d = S_OUT;
					end
				end else if (c_wrap) begin
					ram_we    = 1'b1;
					ram_wdata = '1;
					state_d   = S_COMMIT;
				end else begin
					ram_we  = 1'b1;
					wp_d    = alu_sum[PTR_W-1:0];
					held_d  = held_inc;
					res_d   = '{chunk_count: held_inc, dropped: dropped_q, length: size_q,
					            payload_offset: wp_off, status: ST_OK};
					state_d = S_OUT;
				end
			end
			S_COMMIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				wp_d      = alu_sum[PTR_W-1:0];
				held_d    = held_inc;
				res_d     = '{chunk_count: held_inc, dropped: dropped_q, length: size_q,
				              payload_offset: PTR_W'(HEAD_BYTES), status: ST_OK};
				state_d   = S_OUT;
			end
			S_DCHK: begin
				tries_d = tries_q + 1'b1;
				if (rp_q == wp_q) begin
					res_d   = '{chunk_count: held_q, dropped: dropped_q, length: '0,
					            payload_offset: '0, status: ST_NO_SPACE};
					state_d = S_OUT;
				end else begin
					state_d = S_DLEN;
				end
			end
			S_DLEN: begin
				if (rd_mark) begin
					state_d = S_DW0;
				end else begin
					rp_d      = alu_sum[PTR_W-1:0];
					dropped_d = dropped_inc;
					held_d    = held_dec;
					state_d   = S_RSUM;
				end
			end
			S_DW0: begin
				rp_d      = alu_sum[PTR_W-1:0];
				dropped_d = dropped_inc;
				held_d    = held_dec;
				state_d   = S_RSUM;
			end
			S_TCHK: begin
				if (rp_q == wp_q) begin
					res_d   = '{chunk_count: held_q, dropped: '0, length: '0,
					            payload_offset: '0, status: ST_EMPTY};
					state_d = S_OUT;
				end else begin
					state_d = S_TLEN;
				end
			end
			S_TLEN: begin
				if (rd_mark) begin
					state_d = S_TW0;
				end else if (len_bad_now) begin
					res_d   = '{chunk_count: held_q, dropped: '0, length: '0,
					            payload_offset: '0, status: ST_BAD_LEN};
					state_d = S_OUT;
				end else begin
					rp_d    = alu_sum[PTR_W-1:0];
					held_d  = held_dec;
					res_d   = '{chunk_count: held_dec, dropped: '0, length: rd_len,
					            payload_offset: rp_off, status: ST_OK};
					state_d = S_OUT;
				end
			end
			S_TW0: begin
				if (len_bad_w0) begin
					res_d = '{chunk_count: held_q, dropped: '0, length: '0,
					          payload_offset: '0, status: ST_BAD_LEN};
				end else begin
					rp_d   = alu_sum[PTR_W-1:0];
					held_d = held_dec;
					res_d  = '{chunk_count: held_dec, dropped: '0, length: rd_len,
					           payload_offset: PTR_W'(HEAD_BYTES), status: ST_OK};
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wp_q       <= '0;
			rp_q       <= '0;
			held_q     <= '0;
			usable_q   <= LEN_W'(REGION_BYTES);
			drop_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			held_q  <= held_d;
			if (cfg_we) begin
				if (cfg_index == CFG_USABLE_SIZE) begin
					usable_q <= cfg_data;
				end else begin
					drop_q <= cfg_data[0];
				end
			end
			if ((state_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dropped_q <= dropped_d;
		tries_q   <= tries_d;
		res_q     <= res_d;
		sum_q     <= alu_sum;
		if (accept) begin
			size_q <= s_tdata[LEN_W-1:0];
			need_q <= alu_sum[NEED_W-1:0];
		end
		if ((state_q == S_OUT) && out_free) begin
			out_q <= res_q;
		end
	end

	vrrb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(REGION_BYTES)
	) u_len_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

@@ rtl/vrrb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vrrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/vrrb_checker.sv @@
// ----------------------------------------------------------------------------
// Variable record ring buffer checker
// Port-level checks on the ring buffer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "variable_record_ring_buffer_assert.svh"

module vrrb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [vrrb_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [0:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [vrrb_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            cfg_we,
	input logic [0:0]                      cfg_index,
	input logic [vrrb_pkg::LEN_W-1:0]      cfg_data
);

	import vrrb_pkg::*;

	logic       fail_seen;
	logic       take_seen;
	logic [1:0] res_status;

	assign res_status = m_tdata[1:0];
	assign fail_seen  = m_tvalid && (res_status != ST_OK);
	assign take_seen  = m_tvalid && ((res_status == ST_EMPTY) || (res_status == ST_BAD_LEN));

	`VRRB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`VRRB_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`VRRB_ASSERT_SAME(a_fail_zero, clk, arst_n, fail_seen, m_tdata[26:2] == '0)
	`VRRB_ASSERT_SAME(a_take_no_drop, clk, arst_n, take_seen, m_tdata[36:27] == '0)
	`VRRB_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind variable_record_ring_buffer vrrb_checker u_vrrb_checker (.*);
